@@ sv/cmp_pkg.sv @@
// shared types, codes and decode functions of the coap message parser
`timescale 1ns / 1ps
`default_nettype none
package cmp_pkg;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_TOKEN   = 3'd1,
    PH_OPTION  = 3'd2,
    PH_VALUE   = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_SKIP    = 3'd5,
    PH_MARKER  = 3'd6
  } phase_t;

  // result kinds
  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_TOKEN   = 3'd1;
  localparam logic [2:0] KIND_OPT     = 3'd2;
  localparam logic [2:0] KIND_OPT_VAL = 3'd3;
  localparam logic [2:0] KIND_PAYLOAD = 3'd4;
  localparam logic [2:0] KIND_DONE    = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_VERSION = 3'd1;
  localparam logic [2:0] ST_BAD_TKL     = 3'd2;
  localparam logic [2:0] ST_BAD_CODE    = 3'd3;
  localparam logic [2:0] ST_BAD_OPTION  = 3'd4;
  localparam logic [2:0] ST_TRUNCATED   = 3'd5;

  // code classes
  localparam logic [2:0] CLASS_REQ        = 3'd0;
  localparam logic [2:0] CLASS_SUCCESS    = 3'd2;
  localparam logic [2:0] CLASS_CLIENT_ERR = 3'd4;
  localparam logic [2:0] CLASS_SERVER_ERR = 3'd5;

  localparam logic [1:0] PROTO_VER      = 2'd1;
  localparam logic [1:0] TYPE_RST       = 2'd3;
  localparam logic [3:0] MAX_TKL        = 4'd8;
  localparam logic [7:0] PAYLOAD_MARKER = 8'hFF;
  // allowed option numbers 1,3,4,5,6,7,8,11,12,14,15,17
  localparam logic [31:0] OPTION_SET_MASK = 32'h0002_D9FA;

  localparam int RES_DEPTH_DEF = 4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [7:0]  opt_num;
    logic [3:0]  opt_len;
    logic [1:0]  msg_type;
    logic [3:0]  tok_len;
    logic [7:0]  code;
    logic [15:0] message_id;
    logic [2:0]  status;
    logic        last;
  } result_t;

  // status of the decode stage seen by the top level
  typedef struct packed {
    phase_t     phase;
    logic [1:0] res_cnt;
  } step_stat_t;

  function automatic logic code_ok(input logic [7:0] c);
    logic [2:0] cls;
    logic [4:0] det;
    logic       ok;
    cls = c[7:5];
    det = c[4:0];
    case (cls)
      CLASS_REQ:        ok = (det <= 5'd7);
      CLASS_SUCCESS:    ok = (det inside {[5'd1:5'd5]});
      CLASS_CLIENT_ERR,
      CLASS_SERVER_ERR: ok = (det <= 5'd4);
      default:          ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic option_ok(input logic [7:0] num);
    return (num[7:5] == 3'd0) && OPTION_SET_MASK[num[4:0]];
  endfunction

endpackage
`default_nettype wire

@@ sv/cmp_if.sv @@
// valid/ready channel interfaces for input words and result words
`timescale 1ns / 1ps
`default_nettype none
interface cmp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_message;

  modport source (output valid, output byte_in, output end_of_message, input ready);
  modport sink (input valid, input byte_in, input end_of_message, output ready);
endinterface

interface cmp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  data_byte;
  logic [7:0]  opt_num;
  logic [3:0]  opt_len;
  logic [1:0]  msg_type;
  logic [3:0]  tok_len;
  logic [7:0]  code;
  logic [15:0] message_id;
  logic [2:0]  status;
  logic        last;

  modport source (output valid, output kind, output data_byte, output opt_num,
                  output opt_len, output msg_type, output tok_len,
                  output code, output message_id, output status, output last,
                  input ready);
  modport sink (input valid, input kind, input data_byte, input opt_num,
                input opt_len, input msg_type, input tok_len,
                input code, input message_id, input status, input last,
                output ready);
endinterface
`default_nettype wire

@@ sv/cmp_step.sv @@
// per-byte decode: parser state and the up to two results of one word
`timescale 1ns / 1ps
`default_nettype none
module cmp_step (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  accept,
  input  wire [7:0]            byte_in,
  input  wire                  end_of_message,
  output cmp_pkg::result_t     res0,
  output cmp_pkg::result_t     res1,
  output cmp_pkg::step_stat_t  stat
);
  import cmp_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [3:0] byte_cnt_r, byte_cnt_nxt;
  logic [7:0] fhb_r, fhb_nxt;
  logic [7:0] code_r, code_nxt;
  logic [7:0] idh_r, idh_nxt;
  logic [7:0] opt_r, opt_nxt;
  logic [3:0] vrem_r, vrem_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      byte_cnt_r <= '0;
      fhb_r      <= '0;
      code_r     <= '0;
      idh_r      <= '0;
      opt_r      <= '0;
      vrem_r     <= '0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      fhb_r      <= fhb_nxt;
      code_r     <= code_nxt;
      idh_r      <= idh_nxt;
      opt_r      <= opt_nxt;
      vrem_r     <= vrem_nxt;
    end
  end

  result_t    p, q;
  logic       pv, qv;
  logic [3:0] tkl;
  logic [1:0] typ;
  logic [2:0] hst;
  logic [7:0] num;
  logic [3:0] tok_cnt;
  logic [3:0] vrem_dec;

  always_comb begin
    phase_nxt    = phase_r;
    byte_cnt_nxt = byte_cnt_r;
    fhb_nxt      = fhb_r;
    code_nxt     = code_r;
    idh_nxt      = idh_r;
    opt_nxt      = opt_r;
    vrem_nxt     = vrem_r;
    p  = '0;
    q  = '0;
    pv = 1'b0;
    qv = 1'b0;

    tkl      = fhb_r[3:0];
    typ      = fhb_r[5:4];
    num      = opt_r + {4'd0, byte_in[7:4]};
    tok_cnt  = byte_cnt_r + 4'd1;
    vrem_dec = vrem_r - 4'd1;

    if (fhb_r[7:6] != PROTO_VER) begin
      hst = ST_BAD_VERSION;
    end else if (tkl > MAX_TKL) begin
      hst = ST_BAD_TKL;
    end else if (!code_ok(code_r)) begin
      hst = ST_BAD_CODE;
    end else begin
      hst = ST_OK;
    end

    case (phase_r)
      PH_HEADER: begin
        case (byte_cnt_r)
          4'd0: begin
            fhb_nxt      = byte_in;
            byte_cnt_nxt = 4'd1;
          end
          4'd1: begin
            code_nxt     = byte_in;
            byte_cnt_nxt = 4'd2;
          end
          4'd2: begin
            idh_nxt      = byte_in;
            byte_cnt_nxt = 4'd3;
          end
          default: begin
            byte_cnt_nxt = 4'd0;
            pv           = 1'b1;
            if (hst != ST_OK) begin
              p.kind    = KIND_DONE;
              p.status  = hst;
              phase_nxt = PH_SKIP;
            end else begin
              p.kind       = KIND_HEADER;
              p.msg_type   = typ;
              p.tok_len    = tkl;
              p.code       = code_r;
              p.message_id = {idh_r, byte_in};
              if (typ == TYPE_RST) begin
                // reset message closes right after its header
                qv        = 1'b1;
                q.kind    = KIND_DONE;
                q.status  = ST_OK;
                phase_nxt = PH_SKIP;
              end else begin
                phase_nxt = (tkl != 4'd0) ? PH_TOKEN : PH_OPTION;
              end
            end
          end
        endcase
      end
      PH_TOKEN: begin
        pv           = 1'b1;
        p.kind       = KIND_TOKEN;
        p.data_byte  = byte_in;
        byte_cnt_nxt = tok_cnt;
        if (tok_cnt >= tkl) begin
          byte_cnt_nxt = 4'd0;
          phase_nxt    = PH_OPTION;
        end
      end
      PH_OPTION: begin
        if (byte_in == PAYLOAD_MARKER) begin
          phase_nxt = PH_MARKER;
        end else begin
          opt_nxt = num;
          pv      = 1'b1;
          if (!option_ok(num)) begin
            p.kind    = KIND_DONE;
            p.status  = ST_BAD_OPTION;
            phase_nxt = PH_SKIP;
          end else begin
            p.kind    = KIND_OPT;
            p.opt_num = num;
            p.opt_len = byte_in[3:0];
            vrem_nxt  = byte_in[3:0];
            phase_nxt = (byte_in[3:0] != 4'd0) ? PH_VALUE : PH_OPTION;
          end
        end
      end
      PH_VALUE: begin
        pv          = 1'b1;
        p.kind      = KIND_OPT_VAL;
        p.data_byte = byte_in;
        p.opt_num   = opt_r;
        vrem_nxt    = vrem_dec;
        if (vrem_dec == 4'd0) begin
          phase_nxt = PH_OPTION;
        end
      end
      PH_MARKER, PH_PAYLOAD: begin
        pv          = 1'b1;
        p.kind      = KIND_PAYLOAD;
        p.data_byte = byte_in;
        phase_nxt   = PH_PAYLOAD;
      end
      default: begin
      end
    endcase

    if (end_of_message) begin
      if (phase_nxt != PH_SKIP) begin
        qv     = 1'b1;
        q.kind = KIND_DONE;
        // ending inside header, token, option value or just after the marker
        q.status = (phase_nxt inside {PH_HEADER, PH_TOKEN, PH_VALUE, PH_MARKER}) ?
                   ST_TRUNCATED : ST_OK;
      end
      phase_nxt    = PH_HEADER;
      byte_cnt_nxt = 4'd0;
      opt_nxt      = 8'd0;
      vrem_nxt     = 4'd0;
    end

    // pack results so that the first valid one sits in slot 0
    res0 = pv ? p : q;
    res1 = q;
    stat.phase   = phase_r;
    stat.res_cnt = {1'b0, pv} + {1'b0, qv};
    if (pv && qv) begin
      res1.last = 1'b1;
    end else begin
      res0.last = 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ sv/cmp_res_fifo.sv @@
// result queue: takes up to two results a cycle, hands out one
`timescale 1ns / 1ps
`default_nettype none
module cmp_res_fifo #(
  parameter int DEPTH = cmp_pkg::RES_DEPTH_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire [1:0]                      push_n,
  input  cmp_pkg::result_t               d0,
  input  cmp_pkg::result_t               d1,
  output logic                           room,
  output logic                           out_valid,
  input  wire                            out_ready,
  output cmp_pkg::result_t               out_res,
  output logic [$clog2(DEPTH+1)-1:0]     level
);
  import cmp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

  result_t         mem_r [DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt, wp_1;
  logic [LW-1:0]   cnt_r, cnt_nxt;
  logic            pop;

  always_comb begin
    wp_1    = (wp_r == LAST_IDX) ? '0 : wp_r + PW'(1);
    pop     = out_valid && out_ready;
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    if (push_n == 2'd1) begin
      wp_nxt = wp_1;
    end else if (push_n == 2'd2) begin
      wp_nxt = (wp_1 == LAST_IDX) ? '0 : wp_1 + PW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == LAST_IDX) ? '0 : rp_r + PW'(1);
    end
    cnt_nxt = cnt_r + LW'(push_n) - LW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wp_r] <= d0;
    end
    if (push_n == 2'd2) begin
      mem_r[wp_1] <= d1;
    end
  end

  // room for the worst case of two results from the next word
  assign room      = (cnt_r <= LW'(DEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rp_r];
  assign level     = cnt_r;

endmodule
`default_nettype wire

@@ sv/coap_message_parser_top.sv @@
// top level of the coap message parser: byte channel in, record channel out
//
// usage
//   in_ch carries one message byte per word, end_of_message set on the final
//   byte. out_ch carries records: header, token byte, option start, option
//   value byte, payload byte and a done record with the message status.
//   last marks the final record caused by one input word.
// decode and throughput
//   a word is decoded in the cycle it is accepted; its records pass through
//   the result queue to out_ch in order, a second record (done after header
//   or after an end-of-message byte) following the first. one word per cycle
//   is taken as long as the result queue has two free slots; out_ch drains
//   one record per cycle while ready; two-record words set the sustained rate.
// reset
//   rst_n low returns the parser to the header phase and empties the queue.
// stall
//   when out_ch is held off, up to RES_DEPTH records wait in the queue and
//   in_ch ready drops once fewer than two slots are free. nothing is lost.
`timescale 1ns / 1ps
`default_nettype none
module coap_message_parser_top #(
  parameter int RES_DEPTH = cmp_pkg::RES_DEPTH_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  cmp_in_if.sink       in_ch,
  cmp_out_if.source    out_ch
);
  import cmp_pkg::*;

  localparam int LW = $clog2(RES_DEPTH + 1);

  // word handshake on the input side
  logic            in_accept;
  result_t         res0, res1;
  step_stat_t      stat;
  logic            room;
  logic            out_valid;
  result_t         out_res;
  logic [LW-1:0]   level;
  logic [1:0]      push_n;

  assign in_accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = room;
  assign push_n = in_accept ? stat.res_cnt : 2'd0;

  // byte decode and parser state
  cmp_step u_step (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (in_accept),
    .byte_in        (in_ch.byte_in),
    .end_of_message (in_ch.end_of_message),
    .res0           (res0),
    .res1           (res1),
    .stat           (stat)
  );

  // records wait here until out_ch takes them
  cmp_res_fifo #(
    .DEPTH (RES_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .d0        (res0),
    .d1        (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res),
    .level     (level)
  );

  // unpack the head record onto the output channel
  assign out_ch.valid      = out_valid;
  assign out_ch.kind       = out_res.kind;
  assign out_ch.data_byte  = out_res.data_byte;
  assign out_ch.opt_num    = out_res.opt_num;
  assign out_ch.opt_len    = out_res.opt_len;
  assign out_ch.msg_type   = out_res.msg_type;
  assign out_ch.tok_len    = out_res.tok_len;
  assign out_ch.code       = out_res.code;
  assign out_ch.message_id = out_res.message_id;
  assign out_ch.status     = out_res.status;
  assign out_ch.last       = out_res.last;

`ifndef SYNTHESIS
  // every end of message brings the parser back to the header phase
  a_eom_header: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_ch.end_of_message |=> stat.phase == PH_HEADER)
    else $error("parser not in header phase after end of message");

  // queue never holds more than its depth
  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    level <= LW'(RES_DEPTH))
    else $error("result queue overflow");

  // a second record from one word is always a done record
  a_second_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && stat.res_cnt == 2'd2 |-> res1.kind == KIND_DONE)
    else $error("second record of a word is not done");

  // pushed records show up as queue content
  a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
    push_n != 2'd0 |=> out_valid)
    else $error("pushed record missing from queue");
`endif

endmodule
`default_nettype wire

@@ test/coap_message_parser_top_tb.sv @@
// testbench of coap_message_parser_top: directed and random messages, with a running parse model
`timescale 1ns / 1ps
module coap_message_parser_top_tb;
  import cmp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 200;
  localparam int IDLE_PCT    = 38;
  localparam int TOTAL_WORDS = 800;
  localparam int SETTLE      = 20;

  localparam logic [1:0] MT_CON = 2'd0;
  localparam logic [1:0] MT_NON = 2'd1;
  localparam logic [1:0] MT_ACK = 2'd2;

  typedef logic [7:0] byte_list_t[$];

  logic clk;
  logic rst_n;

  cmp_in_if  in_ch ();
  cmp_out_if out_ch ();

  coap_message_parser_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // records still owed by the block, oldest first
  result_t expected_records[$];

  int          fail_count  = 0;
  int          words_sent  = 0;
  int unsigned cycle_count = 0;
  bit          steady      = 1'b0;
  int          stall_asks  = 0;
  int          stall_served = 0;
  int          hold_left   = 0;

  // running parse state of the message in flight
  phase_t     parse_phase;
  logic [3:0] hdr_index;
  logic [3:0] token_seen;
  logic [3:0] value_left;
  logic [7:0] hdr_first;
  logic [7:0] hdr_code;
  logic [7:0] hdr_id_high;
  logic [7:0] option_acc;

  function automatic logic option_listed(input logic [7:0] num);
    case (num)
      8'd1, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd11, 8'd12, 8'd14, 8'd15, 8'd17: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic code_valid(input logic [7:0] c);
    case (c[7:5])
      CLASS_REQ:        return c[4:0] < 5'd8;
      CLASS_SUCCESS:    return (c[4:0] != 5'd0) && (c[4:0] < 5'd6);
      CLASS_CLIENT_ERR,
      CLASS_SERVER_ERR: return c[4:0] < 5'd5;
      default:          return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] head_byte(input logic [1:0] ver, input logic [1:0] mt,
                                           input logic [3:0] tkl);
    return {ver, mt, tkl};
  endfunction

  function automatic void start_message();
    parse_phase = PH_HEADER;
    hdr_index   = 4'd0;
    token_seen  = 4'd0;
    value_left  = 4'd0;
    option_acc  = 8'd0;
  endfunction

  function automatic void queue_record(input logic [2:0] kind, input logic [7:0] data,
                                       input logic [7:0] onum, input logic [3:0] olen,
                                       input logic [1:0] mt, input logic [3:0] tkl,
                                       input logic [7:0] code, input logic [15:0] mid,
                                       input logic [2:0] st);
    result_t r;
    r = '{kind: kind, data_byte: data, opt_num: onum, opt_len: olen,
          msg_type: mt, tok_len: tkl, code: code, message_id: mid,
          status: st, last: 1'b0};
    expected_records.push_back(r);
  endfunction

  // advance the parse by one accepted word and queue the records it causes
  function automatic void parse_word(input logic [7:0] b, input logic eom);
    int         first_new;
    logic [2:0] err;
    logic [3:0] tkl;
    logic [1:0] mt;
    logic [7:0] num;
    first_new = expected_records.size();
    case (parse_phase)
      PH_HEADER: begin
        if (hdr_index != 4'd3) begin
          case (hdr_index)
            4'd0:    hdr_first = b;
            4'd1:    hdr_code = b;
            default: hdr_id_high = b;
          endcase
          hdr_index = hdr_index + 4'd1;
        end else begin
          hdr_index = 4'd0;
          tkl = hdr_first[3:0];
          mt  = hdr_first[5:4];
          if (hdr_first[7:6] != PROTO_VER)    err = ST_BAD_VERSION;
          else if (tkl > MAX_TKL)             err = ST_BAD_TKL;
          else if (!code_valid(hdr_code))     err = ST_BAD_CODE;
          else                                err = ST_OK;
          if (err != ST_OK) begin
            queue_record(KIND_DONE, 0, 0, 0, 0, 0, 0, 0, err);
            parse_phase = PH_SKIP;
          end else begin
            queue_record(KIND_HEADER, 0, 0, 0, mt, tkl, hdr_code, {hdr_id_high, b}, ST_OK);
            if (mt == TYPE_RST) begin
              // reset-type message closes right after its header
              queue_record(KIND_DONE, 0, 0, 0, 0, 0, 0, 0, ST_OK);
              parse_phase = PH_SKIP;
            end else begin
              parse_phase = (tkl != 4'd0) ? PH_TOKEN : PH_OPTION;
            end
          end
        end
      end
      PH_TOKEN: begin
        queue_record(KIND_TOKEN, b, 0, 0, 0, 0, 0, 0, ST_OK);
        token_seen = token_seen + 4'd1;
        if (token_seen >= hdr_first[3:0]) begin
          token_seen  = 4'd0;
          parse_phase = PH_OPTION;
        end
      end
      PH_OPTION: begin
        if (b == PAYLOAD_MARKER) begin
          parse_phase = PH_MARKER;
        end else begin
          // delta nibble is taken literally, no extended forms
          num = option_acc + {4'd0, b[7:4]};
          option_acc = num;
          if (!option_listed(num)) begin
            queue_record(KIND_DONE, 0, 0, 0, 0, 0, 0, 0, ST_BAD_OPTION);
            parse_phase = PH_SKIP;
          end else begin
            queue_record(KIND_OPT, 0, num, b[3:0], 0, 0, 0, 0, ST_OK);
            value_left  = b[3:0];
            parse_phase = (b[3:0] != 4'd0) ? PH_VALUE : PH_OPTION;
          end
        end
      end
      PH_VALUE: begin
        queue_record(KIND_OPT_VAL, b, option_acc, 0, 0, 0, 0, 0, ST_OK);
        value_left = value_left - 4'd1;
        if (value_left == 4'd0) parse_phase = PH_OPTION;
      end
      PH_MARKER, PH_PAYLOAD: begin
        queue_record(KIND_PAYLOAD, b, 0, 0, 0, 0, 0, 0, ST_OK);
        parse_phase = PH_PAYLOAD;
      end
      default: ;
    endcase
    if (eom) begin
      // a skipped message ends silently
      if (parse_phase != PH_SKIP)
        queue_record(KIND_DONE, 0, 0, 0, 0, 0, 0, 0,
                     (parse_phase inside {PH_HEADER, PH_TOKEN, PH_VALUE, PH_MARKER}) ?
                     ST_TRUNCATED : ST_OK);
      start_message();
    end
    if (expected_records.size() > first_new)
      expected_records[expected_records.size() - 1].last = 1'b1;
  endfunction

  function automatic string rec_text(input result_t r);
    return $sformatf({"kind=%0d data=%02h opt=%0d len=%0d type=%0d tkl=%0d",
                      " code=%02h id=%04h st=%0d last=%0d"},
                     r.kind, r.data_byte, r.opt_num, r.opt_len, r.msg_type,
                     r.tok_len, r.code, r.message_id, r.status, r.last);
  endfunction

  task automatic note_failure(input string what, input string detail);
    fail_count++;
    if (fail_count <= 10) $display("%0t ns: %s %s", $time, what, detail);
  endtask

  // record checker
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{kind: out_ch.kind, data_byte: out_ch.data_byte,
              opt_num: out_ch.opt_num, opt_len: out_ch.opt_len,
              msg_type: out_ch.msg_type, tok_len: out_ch.tok_len,
              code: out_ch.code, message_id: out_ch.message_id, status: out_ch.status,
              last: out_ch.last};
      if (expected_records.size() == 0) begin
        note_failure("unexpected record:", rec_text(got));
      end else begin
        want = expected_records.pop_front();
        if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
            got.opt_num !== want.opt_num ||
            got.opt_len !== want.opt_len ||
            got.msg_type !== want.msg_type ||
            got.tok_len !== want.tok_len || got.code !== want.code ||
            got.message_id !== want.message_id || got.status !== want.status ||
            got.last !== want.last)
          note_failure("record mismatch:",
                       {"expected ", rec_text(want), " got ", rec_text(got)});
      end
    end
  end

  // receiver: random stalls, long hold-offs on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_asks != stall_served) begin
        stall_served = stall_asks;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("** coap_message_parser_top: FAILED **");
    $finish;
  end

  // offer one word from a falling edge; returns at the falling edge after acceptance,
  // with valid still high
  task automatic send_word(input logic [7:0] b, input logic eom);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.byte_in        <= b;
    in_ch.end_of_message <= eom;
    do @(posedge clk); while (!in_ch.ready);
    parse_word(b, eom);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(input byte_list_t m);
    int i;
    for (i = 0; i < m.size(); i++) send_word(m[i], i == m.size() - 1);
  endtask

  // sender pauses until every owed record has come out
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (expected_records.size() != 0) @(negedge clk);
  endtask

  // mostly well-formed messages with random content, the rest damaged or noise
  function automatic byte_list_t make_message();
    byte_list_t m;
    logic [1:0] mt;
    logic [3:0] tkl;
    logic [3:0] len;
    logic [3:0] delta;
    logic [7:0] onum;
    logic [7:0] ob;
    logic [2:0] cls;
    logic [4:0] det;
    int         nopt;
    int         i;
    int         tries;
    int         cut;
    bit         found;
    mt  = ($urandom_range(9) == 0) ? TYPE_RST : 2'($urandom_range(2));
    tkl = 4'($urandom_range(8));
    case ($urandom_range(3))
      0:       begin cls = CLASS_REQ;        det = 5'($urandom_range(7));    end
      1:       begin cls = CLASS_SUCCESS;    det = 5'($urandom_range(5, 1)); end
      2:       begin cls = CLASS_CLIENT_ERR; det = 5'($urandom_range(4));    end
      default: begin cls = CLASS_SERVER_ERR; det = 5'($urandom_range(4));    end
    endcase
    m.push_back(head_byte(PROTO_VER, mt, tkl));
    m.push_back({cls, det});
    m.push_back(8'($urandom));
    m.push_back(8'($urandom));
    repeat (tkl) m.push_back(8'($urandom));
    onum = 8'd0;
    nopt = $urandom_range(3);
    for (i = 0; i < nopt; i++) begin
      found = 1'b0;
      for (tries = 0; tries < 16 && !found; tries++) begin
        delta = 4'($urandom);
        found = option_listed(onum + {4'd0, delta});
      end
      if (!found) break;
      onum = onum + {4'd0, delta};
      len  = ($urandom_range(7) == 0) ? 4'($urandom) : 4'($urandom_range(3));
      ob   = {delta, len};
      if (ob == PAYLOAD_MARKER) begin
        len = 4'd14;
        ob  = {delta, len};
      end
      m.push_back(ob);
      repeat (len) m.push_back(8'($urandom));
    end
    // payload may be empty: marker at the very end
    if ($urandom_range(2) != 0) begin
      m.push_back(PAYLOAD_MARKER);
      repeat ($urandom_range(8)) m.push_back(8'($urandom));
    end
    case ($urandom_range(11))
      0: begin
        cut = $urandom_range(m.size() - 1);
        m   = m[0:cut];
      end
      1: m[$urandom_range(m.size() - 1)] = 8'($urandom);
      2: begin
        m.delete();
        repeat ($urandom_range(12, 1)) m.push_back(8'($urandom));
      end
      default: ;
    endcase
    return m;
  endfunction

  // header, token, option with value, literal delta 14, payload; extreme id and byte values
  task automatic test_full_message();
    send_message('{head_byte(PROTO_VER, MT_ACK, 4'd1), {CLASS_SERVER_ERR, 5'd4},
                   8'hFF, 8'hFF, 8'hFF, 8'h11, 8'h00, 8'hE0, PAYLOAD_MARKER, 8'hFF});
    send_message('{head_byte(PROTO_VER, MT_NON, 4'd0), {CLASS_REQ, 5'd0},
                   8'h00, 8'h00});
  endtask

  // reset type stops at the header; trailing word is skipped
  task automatic test_reset_type();
    send_message('{head_byte(PROTO_VER, TYPE_RST, 4'd0), {CLASS_SUCCESS, 5'd1},
                   8'h5A, 8'hA5, 8'h11});
  endtask

  task automatic test_header_errors();
    send_message('{head_byte(2'd2, MT_CON, 4'd0), {CLASS_REQ, 5'd1}, 8'h00, 8'h01});
    send_message('{head_byte(PROTO_VER, MT_CON, 4'd9), {CLASS_REQ, 5'd1}, 8'h00, 8'h02});
    send_message('{head_byte(PROTO_VER, MT_NON, 4'd0), {3'd1, 5'd0}, 8'h00, 8'h03,
                   8'h44});
  endtask

  // option number 2 is not in the allowed set
  task automatic test_bad_option();
    send_message('{head_byte(PROTO_VER, MT_CON, 4'd0), {CLASS_CLIENT_ERR, 5'd0},
                   8'h12, 8'h34, 8'h20, 8'h11});
  endtask

  // end inside the header and right after the payload marker
  task automatic test_early_end();
    send_message('{head_byte(PROTO_VER, MT_CON, 4'd0)});
    send_message('{head_byte(PROTO_VER, MT_CON, 4'd0), {CLASS_REQ, 5'd2},
                   8'h00, 8'h04, PAYLOAD_MARKER});
  endtask

  // receiver holds off while a long payload keeps coming, so the input must stall
  task automatic test_backpressure();
    byte_list_t m;
    m = '{head_byte(PROTO_VER, MT_NON, 4'd0), {CLASS_REQ, 5'd1}, 8'($urandom),
          8'($urandom), PAYLOAD_MARKER};
    repeat (40) m.push_back(8'($urandom));
    steady     <= 1'b1;
    stall_asks <= stall_asks + 1;
    send_message(m);
    wait_drain();
    steady <= 1'b0;
  endtask

  // back-to-back words with the receiver always ready
  task automatic test_streaming();
    int start;
    start  = words_sent;
    steady <= 1'b1;
    while (words_sent < start + 150) send_message(make_message());
    wait_drain();
    steady <= 1'b0;
  endtask

  task automatic test_random_traffic();
    while (words_sent < TOTAL_WORDS) send_message(make_message());
  endtask

  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.byte_in        = 8'h00;
    in_ch.end_of_message = 1'b0;
    start_message();
    hdr_first   = 8'h00;
    hdr_code    = 8'h00;
    hdr_id_high = 8'h00;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_full_message();
    test_reset_type();
    test_header_errors();
    test_bad_option();
    test_early_end();
    test_backpressure();
    test_streaming();
    test_random_traffic();

    wait_drain();
    repeat (SETTLE) @(negedge clk);
    if (expected_records.size() != 0)
      note_failure("records never delivered:", $sformatf("%0d", expected_records.size()));
    if (fail_count == 0)
      $display("** coap_message_parser_top: PASSED **");
    else
      $display("** coap_message_parser_top: FAILED **");
    $finish;
  end

endmodule

@@ files.f @@
sv/cmp_pkg.sv
sv/cmp_if.sv
sv/cmp_step.sv
sv/cmp_res_fifo.sv
sv/coap_message_parser_top.sv
test/coap_message_parser_top_tb.sv
